[design/pvd_pkg.sv]
// Shared types, constants, microprogram and arithmetic helpers for the polynomial evaluator.
package pvd_pkg;

    localparam int MAX_COEFFS = 7;
    localparam int NUM_COEF   = 7;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int K_W        = 3;
    localparam int OP_W       = 2;
    localparam int FACT_W     = 5;
    localparam int ADDR_W     = 5;
    localparam int REG_IDX_W  = 3;
    localparam int WIDE_W     = 48;
    localparam int PROD_W     = 2 * DATA_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_VALUE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DERIV1 = 2'd1;
    localparam logic [OP_W-1:0] OP_DERIV2 = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF0 = 3'd1;

    // Microprogram addresses
    typedef logic [2:0] upc_t;
    localparam upc_t UPC_IDLE  = 3'd0;
    localparam upc_t UPC_CHECK = 3'd1;
    localparam upc_t UPC_TOP   = 3'd2;
    localparam upc_t UPC_MUL   = 3'd3;
    localparam upc_t UPC_ADD   = 3'd4;
    localparam upc_t UPC_DONE  = 3'd5;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_BR_NOWORK,
        COND_BR_LAST,
        COND_LOOP_MORE,
        COND_WAIT_OUT
    } seq_cond_t;

    typedef struct packed {
        logic      accept;
        logic      init;
        logic      top_load;
        logic      mul;
        logic      add;
        logic      dec_k;
        logic      emit;
        seq_cond_t cond;
        upc_t      target;
    } ucode_t;

    typedef struct packed {
        logic init;
        logic top_load;
        logic mul;
        logic add;
        logic dec_k;
    } dp_ctl_t;

    typedef struct packed {
        logic last;
        logic nowork;
    } dp_stat_t;

    typedef struct packed {
        logic                     ovf;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t word;
        word        = '0;
        word.cond   = COND_NEXT;
        word.target = UPC_IDLE;
        case (pc)
            UPC_IDLE:
            begin
                word.accept = 1'b1;
                word.init   = 1'b1;
                word.cond   = COND_WAIT_IN;
                word.target = UPC_CHECK;
            end
            UPC_CHECK:
            begin
                word.cond   = COND_BR_NOWORK;
                word.target = UPC_DONE;
            end
            UPC_TOP:
            begin
                word.top_load = 1'b1;
                word.dec_k    = 1'b1;
                word.cond     = COND_BR_LAST;
                word.target   = UPC_DONE;
            end
            UPC_MUL:
            begin
                word.mul  = 1'b1;
                word.cond = COND_NEXT;
            end
            UPC_ADD:
            begin
                word.add    = 1'b1;
                word.dec_k  = 1'b1;
                word.cond   = COND_LOOP_MORE;
                word.target = UPC_MUL;
            end
            UPC_DONE:
            begin
                word.emit   = 1'b1;
                word.cond   = COND_WAIT_OUT;
                word.target = UPC_IDLE;
            end
            default:
            begin
                word.cond   = COND_WAIT_OUT;
                word.target = UPC_IDLE;
            end
        endcase
        return word;
    endfunction

    // Integer factor of coefficient k for the selected derivative
    function automatic logic [FACT_W-1:0] coef_factor(input logic [K_W-1:0] k,
                                                      input logic [OP_W-1:0] op);
        logic [FACT_W-1:0] f;
        case (op)
            OP_VALUE:  f = FACT_W'(1);
            OP_DERIV1: f = FACT_W'(k);
            OP_DERIV2: f = FACT_W'(k) * (FACT_W'(k) - FACT_W'(1));
            default:   f = FACT_W'(1);
        endcase
        return f;
    endfunction

    // Clamp a wide signed value to 32 bits and flag saturation
    function automatic sat_t sat48(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        if (v > WIDE_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (v < WIDE_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
            r.ovf = 1'b1;
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else begin
            r.ovf = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/pvd_cfg.sv]
// Configuration register bank with APB-style write and read access.
module pvd_cfg
    import pvd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic [K_W-1:0]           count,
    output logic signed [DATA_W-1:0] coef [NUM_COEF]
);

    logic [REG_IDX_W-1:0]     reg_idx;
    logic [REG_IDX_W-1:0]     coef_idx;
    logic                     wr_en;
    logic [K_W-1:0]           count_reg;
    logic signed [DATA_W-1:0] coef_reg [NUM_COEF];

    assign reg_idx  = paddr[ADDR_W-1:2];
    assign coef_idx = REG_IDX_W'(reg_idx - REG_COEF0);
    assign wr_en    = psel & penable & pwrite;

    // Write on the access cycle of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en) begin
            case (reg_idx)
                REG_COUNT: count_reg          <= pwdata[K_W-1:0];
                default:   coef_reg[coef_idx] <= pwdata;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_COUNT: prdata = DATA_W'(count_reg);
            default:   prdata = coef_reg[coef_idx];
        endcase
    end

    assign count = count_reg;
    assign coef  = coef_reg;

endmodule

[design/pvd_seq.sv]
// Microcode sequencer: step counter, control store lookup and branch logic.
module pvd_seq
    import pvd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_free,
    input  dp_stat_t stat,
    output logic     in_ready,
    output logic     out_load,
    output dp_ctl_t  ctl
);

    upc_t   pc_reg;
    upc_t   pc_next;
    upc_t   pc_inc;
    ucode_t word;

    assign word   = ucode_rom(pc_reg);
    assign pc_inc = upc_t'(pc_reg + 1'b1);

    // Pick the next step
    always_comb
    begin
        pc_next = pc_reg;
        case (word.cond)
            COND_NEXT:      pc_next = pc_inc;
            COND_WAIT_IN:   pc_next = in_fire ? word.target : pc_reg;
            COND_BR_NOWORK: pc_next = stat.nowork ? word.target : pc_inc;
            COND_BR_LAST:   pc_next = stat.last ? word.target : pc_inc;
            COND_LOOP_MORE: pc_next = stat.last ? pc_inc : word.target;
            COND_WAIT_OUT:  pc_next = out_free ? word.target : pc_reg;
            default:        pc_next = UPC_IDLE;
        endcase
    end

    // Hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg <= UPC_IDLE;
        end
        else begin
            pc_reg <= pc_next;
        end
    end

    // Drive the datapath from the control word
    assign in_ready     = word.accept;
    assign out_load     = word.emit & out_free;
    assign ctl.init     = word.init & in_fire;
    assign ctl.top_load = word.top_load;
    assign ctl.mul      = word.mul;
    assign ctl.add      = word.add;
    assign ctl.dec_k    = word.dec_k & ~stat.last;

endmodule

[design/pvd_dp.sv]
// Datapath: coefficient scaler, shared multiply-accumulate and term counter.
module pvd_dp
    import pvd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_ctl_t                  ctl,
    input  logic [K_W-1:0]           count,
    input  logic signed [DATA_W-1:0] coef [NUM_COEF],
    input  logic signed [DATA_W-1:0] point,
    input  logic [OP_W-1:0]          operation,
    output dp_stat_t                 stat,
    output logic signed [DATA_W-1:0] result,
    output logic                     overflow
);

    logic [K_W-1:0]              n_eff;
    logic [K_W-1:0]              k_reg;
    logic [OP_W-1:0]             op_reg;
    logic signed [DATA_W-1:0]    x_reg;
    logic signed [DATA_W-1:0]    acc_reg;
    logic signed [DATA_W-1:0]    b_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        ovf_reg;

    logic signed [DATA_W-1:0]    coef_sel;
    logic signed [FACT_W:0]      fact_s;
    logic signed [DATA_W+FACT_W:0] sprod;
    sat_t                        sb;
    logic signed [PROD_W-1:0]    mprod;
    logic signed [PROD_W-1:0]    rsum;
    sat_t                        rq;
    logic signed [DATA_W:0]      sum33;
    sat_t                        sa;

    assign n_eff = (count > K_W'(MAX_COEFFS)) ? K_W'(MAX_COEFFS) : count;

    // Term status for the sequencer
    assign stat.last   = (k_reg == K_W'(op_reg));
    assign stat.nowork = (n_eff <= K_W'(op_reg)) || (op_reg > OP_DERIV2);

    // Scale the current coefficient by its derivative factor
    assign coef_sel = coef[k_reg];
    assign fact_s   = $signed({1'b0, coef_factor(k_reg, op_reg)});
    assign sprod    = coef_sel * fact_s;
    assign sb       = sat48(WIDE_W'(sprod));

    // Multiply, then round half up, clamp and add the scaled coefficient
    assign mprod = acc_reg * x_reg;
    assign rsum  = prod_reg + PROD_W'(1 << (FRAC_W - 1));
    assign rq    = sat48($signed(rsum[PROD_W-1:FRAC_W]));
    assign sum33 = (DATA_W+1)'(rq.val) + (DATA_W+1)'(b_reg);
    assign sa    = sat48(WIDE_W'(sum33));

    // Accumulator, term counter and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg   <= '0;
            op_reg  <= '0;
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else begin
            if (ctl.init) begin
                k_reg   <= K_W'(n_eff - 1'b1);
                op_reg  <= operation;
                acc_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else begin
                if (ctl.dec_k) begin
                    k_reg <= K_W'(k_reg - 1'b1);
                end
                if (ctl.top_load) begin
                    acc_reg <= sb.val;
                    ovf_reg <= ovf_reg | sb.ovf;
                end
                else if (ctl.mul) begin
                    ovf_reg <= ovf_reg | sb.ovf;
                end
                else if (ctl.add) begin
                    acc_reg <= sa.val;
                    ovf_reg <= ovf_reg | rq.ovf | sa.ovf;
                end
            end
        end
    end

    // Operand and product registers
    always_ff @(posedge clk)
    begin
        if (ctl.init) begin
            x_reg <= point;
        end
        if (ctl.mul) begin
            prod_reg <= mprod;
            b_reg    <= sb.val;
        end
    end

    assign result   = acc_reg;
    assign overflow = ovf_reg;

endmodule

[design/polynomial_value_and_derivatives.sv]
// Top level of the polynomial value and derivative evaluator.
//
//  channel  | direction | handshake                  | contents
//  s_axis   | in        | tvalid / tready            | tdata: point; tuser: operation
//  m_axis   | out       | tvalid / tready            | tdata: result_value; tuser: overflow
//  apb      | in        | psel, penable, pwrite      | count at 0x00, coef_0..coef_6 at 0x04..0x1C
//
// An item with m terms (m = count - operation) runs the check and top steps, the loop below, then the done step;
// with no terms the check step branches straight to the done step.
// Each term after the leading one takes two microsteps of the shared multiply-accumulate:
// multiply, then round, clamp and add.
// The input is ready again in the cycle after the one that loads a result into the output register.
// A stalled output holds the sequencer in its final step only while the output register is full.
// Reset is asynchronous; it clears the step counter, output valid, config registers, accumulator and overflow flag.
module polynomial_value_and_derivatives
    import pvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] point
    input  logic [OP_W-1:0]   s_axis_tuser,   // [1:0] operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] result_value
    output logic [0:0]        m_axis_tuser,   // [0] overflow
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [K_W-1:0]           count;
    logic signed [DATA_W-1:0] coef [NUM_COEF];
    logic                     in_fire;
    logic                     out_free;
    logic                     out_load;
    dp_ctl_t                  ctl;
    dp_stat_t                 stat;
    logic signed [DATA_W-1:0] dp_result;
    logic                     dp_overflow;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_data_reg;
    logic                     out_ovf_reg;

    assign pready   = 1'b1;
    assign in_fire  = s_axis_tvalid & s_axis_tready;
    assign out_free = ~out_valid_reg | m_axis_tready;

    pvd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .count   (count),
        .coef    (coef)
    );

    pvd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .out_load (out_load),
        .ctl      (ctl)
    );

    pvd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .count     (count),
        .coef      (coef),
        .point     ($signed(s_axis_tdata)),
        .operation (s_axis_tuser),
        .stat      (stat),
        .result    (dp_result),
        .overflow  (dp_overflow)
    );

    // Output register: load a finished result, drop it after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load) begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_data_reg <= dp_result;
            out_ovf_reg  <= dp_overflow;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

[design/pvd_checker.sv]
// Port-level checks for the polynomial evaluator, bound to the top level.
module pvd_checker
    import pvd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [0:0]        m_axis_tuser,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    logic s_fire;
    logic cfg_wr;

    assign s_fire = s_axis_tvalid & s_axis_tready;
    assign cfg_wr = psel & penable & pwrite & pready;

    // No result is offered while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // After a transfer the input stays closed through the check step and the step that follows it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened too early");

    // A write to coef_0 at 0x04 reads back while the address stays there
    a_coef_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr == ADDR_W'(4)) ##1 (paddr == ADDR_W'(4)) |->
            prdata == $past(pwdata))
        else $error("coefficient readback mismatch");

endmodule

bind polynomial_value_and_derivatives pvd_checker u_pvd_checker (.*);

[bench/pvd_checker.sv]
// Scoreboard for the polynomial evaluator: tracks register writes, predicts results, compares them.
module pvd_scoreboard
    import pvd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] point
    input  logic [OP_W-1:0]   s_axis_tuser,   // [1:0] operation
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,   // [31:0] result_value
    input  logic [0:0]        m_axis_tuser,   // [0] overflow
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                fail_count,
    output int                pending_count
);

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } poly_out_t;

    logic [K_W-1:0]           term_count;
    logic signed [DATA_W-1:0] coef [NUM_COEF];
    poly_out_t                expected_q [$];
    int                       errors;

    function automatic longint clamp_s32(input longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    // Horner evaluation of the value or a derivative with saturating Q16.16 steps
    function automatic poly_out_t eval_poly(input logic signed [DATA_W-1:0] x,
                                            input logic [OP_W-1:0] op);
        poly_out_t r;
        int        n;
        int        k;
        longint    factor;
        longint    term;
        longint    acc;
        longint    t;
        logic      ovf;
        n   = int'(term_count);
        acc = 0;
        ovf = 1'b0;
        if (n > MAX_COEFFS)
            n = MAX_COEFFS;
        if (op <= OP_DERIV2 && n > int'(op))
        begin
            for (k = n - 1; k >= int'(op); k--)
            begin
                case (op)
                    OP_DERIV1: factor = k;
                    OP_DERIV2: factor = k * (k - 1);
                    default:   factor = 1;
                endcase
                t    = longint'(coef[k]) * factor;
                term = clamp_s32(t);
                if (term != t)
                    ovf = 1'b1;
                if (k == n - 1)
                    acc = term;
                else
                begin
                    // round half up, then clamp the product and the sum
                    t   = (acc * longint'(x) + 64'sd32768) >>> 16;
                    acc = clamp_s32(t);
                    if (acc != t)
                        ovf = 1'b1;
                    t   = acc + term;
                    acc = clamp_s32(t);
                    if (acc != t)
                        ovf = 1'b1;
                end
            end
        end
        r.val = DATA_W'(acc);
        r.ovf = ovf;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        poly_out_t              want;
        logic [REG_IDX_W-1:0]   reg_idx;
        if (!rst_n)
        begin
            term_count = '0;
            for (int i = 0; i < NUM_COEF; i++)
                coef[i] = '0;
            expected_q.delete();
            pending_count <= 0;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                reg_idx = paddr[ADDR_W-1:2];
                if (reg_idx == REG_COUNT)
                    term_count = pwdata[K_W-1:0];
                else
                    coef[reg_idx - REG_COEF0] = pwdata;
            end

            // Compare each output transfer with the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result_value: expected none, actual %0d", $signed(m_axis_tdata));
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata !== want.val)
                    begin
                        $error("result_value: expected %0d, actual %0d",
                               want.val, $signed(m_axis_tdata));
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.ovf)
                    begin
                        $error("overflow: expected %0b, actual %0b", want.ovf, m_axis_tuser[0]);
                        errors++;
                    end
                end
            end

            // Predict each input transfer
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(eval_poly(s_axis_tdata, s_axis_tuser));

            pending_count <= expected_q.size();
        end
        fail_count <= errors;
    end

endmodule

[bench/tb_polynomial_value_and_derivatives.sv]
// Top of the polynomial evaluator bench: clock, reset, register setup, stimulus and verdict.
module tb_polynomial_value_and_derivatives;
    import pvd_pkg::*;

    localparam logic [OP_W-1:0]          OP_NONE = 2'd3;
    localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh00010000;
    localparam logic signed [DATA_W-1:0] Q_HALF  = 32'sh00008000;

    localparam int MODE_SMALL   = 0;
    localparam int MODE_FULL    = 1;
    localparam int MODE_EXTREME = 2;

    localparam int NUM_PHASES       = 20;
    localparam int ITEMS_PER_PHASE  = 82;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;    // [31:0] point
    logic [OP_W-1:0]   s_axis_tuser;    // [1:0] operation
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;    // [31:0] result_value
    logic [0:0]        m_axis_tuser;    // [0] overflow
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_count;
    int out_stall_pct = 0;
    int in_gap_pct    = 0;
    int stall_left    = 0;

    logic signed [DATA_W-1:0] coef_set [NUM_COEF];

    polynomial_value_and_derivatives uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pvd_scoreboard u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold off the result channel in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 6);
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic signed [DATA_W-1:0] rand_coef(input int mode);
        case (mode)
            MODE_SMALL:   return DATA_W'(int'($urandom_range(0, 524288)) - 262144);
            MODE_FULL:    return $urandom();
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return '1;
                    4:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_point();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return DATA_W'(int'($urandom_range(0, 262144)) - 131072);
        if (pick < 80)
            return DATA_W'(int'($urandom_range(0, 33554432)) - 16777216);
        if (pick < 92)
            return $urandom();
        case ($urandom_range(0, 6))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return 32'sd1;
            4:       return '1;
            5:       return Q_HALF;
            default: return Q_ONE;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return OP_VALUE;
        if (pick < 6)
            return OP_DERIV1;
        if (pick < 9)
            return OP_DERIV2;
        return OP_NONE;
    endfunction

    // One register write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write the term count, with junk in the unused bits, and all coefficients
    task automatic load_poly(input int cnt);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        apb_write(REG_COUNT, {junk[DATA_W-1:K_W], K_W'(cnt)});
        for (int k = 0; k < NUM_COEF; k++)
            apb_write(REG_IDX_W'(REG_COEF0 + k), coef_set[k]);
    endtask

    // Offer one item, optionally after an idle burst, and hold it until the transfer
    task automatic send_item(input logic signed [DATA_W-1:0] pt, input logic [OP_W-1:0] op);
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pt;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic fill_coefs(input logic signed [DATA_W-1:0] v);
        for (int k = 0; k < NUM_COEF; k++)
            coef_set[k] = v;
    endtask

    initial
    begin
        int coef_mode;
        int cnt;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: no terms, every operation gives zero
        send_item('0, OP_VALUE);
        send_item(Q_MAX, OP_DERIV1);
        send_item(Q_MIN, OP_DERIV2);
        send_item(Q_ONE, OP_NONE);
        drain();

        // Seven unit coefficients across the point extremes
        fill_coefs(Q_ONE);
        load_poly(MAX_COEFFS);
        send_item('0, OP_VALUE);
        send_item(Q_ONE, OP_VALUE);
        send_item(-Q_ONE, OP_DERIV1);
        send_item(Q_HALF, OP_DERIV2);
        send_item(Q_MAX, OP_VALUE);
        send_item(Q_MIN, OP_DERIV1);
        send_item(Q_ONE, OP_NONE);
        drain();

        // Too few terms for the derivative
        load_poly(1);
        send_item(Q_ONE, OP_VALUE);
        send_item(Q_ONE, OP_DERIV1);
        drain();
        load_poly(2);
        send_item(Q_HALF, OP_DERIV1);
        send_item(Q_HALF, OP_DERIV2);
        drain();

        // Saturating coefficients: scaling, products and sums clamp
        fill_coefs(Q_MAX);
        load_poly(MAX_COEFFS);
        send_item(Q_ONE, OP_DERIV2);
        send_item(Q_MAX, OP_VALUE);
        drain();
        fill_coefs(Q_MIN);
        load_poly(MAX_COEFFS);
        send_item(-Q_ONE, OP_DERIV1);
        send_item(Q_MIN, OP_VALUE);
        drain();

        // Random phases, each with a fresh polynomial; the last ones run without idling
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase >= NUM_PHASES - 2)
            begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end
            else
            begin
                in_gap_pct    = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
                out_stall_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 40);
            end
            coef_mode = $urandom_range(0, 9);
            for (int k = 0; k < NUM_COEF; k++)
            begin
                if (coef_mode < 6)
                    coef_set[k] = rand_coef(MODE_SMALL);
                else if (coef_mode < 8)
                    coef_set[k] = rand_coef($urandom_range(MODE_SMALL, MODE_EXTREME));
                else
                    coef_set[k] = rand_coef(coef_mode == 8 ? MODE_FULL : MODE_EXTREME);
            end
            cnt = ($urandom_range(0, 9) < 7) ? $urandom_range(5, MAX_COEFFS) : $urandom_range(0, 4);
            load_poly(cnt);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(rand_point(), rand_op());
            drain();
        end

        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Bound the run well beyond the slowest legal pace
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
